>>> design/scl_pkg.sv
// Shared types, codes, character constants and class functions for the shell command lexer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package scl_pkg;

    // Result queue geometry
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    // Worst case number of results caused by one input item
    localparam int MAXRES = 3;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_VAR   = 3'd2,
        MODE_SQ    = 3'd3,
        MODE_DQ    = 3'd4,
        MODE_DQESC = 3'd5,
        MODE_DQVAR = 3'd6,
        MODE_DISC  = 3'd7
    } lex_mode_t;

    typedef enum logic [1:0] {
        KIND_CHAR      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } item_kind_t;

    typedef enum logic [2:0] {
        TOK_WORD   = 3'd0,
        TOK_PATH   = 3'd1,
        TOK_VAR    = 3'd2,
        TOK_SQUOTE = 3'd3,
        TOK_DQUOTE = 3'd4,
        TOK_PIPE   = 3'd5
    } token_kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ILLEGAL   = 2'd1,
        ST_UNCLOSED  = 2'd2,
        ST_EMPTY_VAR = 2'd3
    } line_status_t;

    // One result item
    typedef struct packed {
        logic [1:0] item_kind;
        logic [7:0] out_char;
        logic [2:0] token_kind;
        logic       var_start;
        logic [1:0] line_status;
        logic       last_of_run;
    } result_t;

    // Results of one lexing step, handed to the queue
    typedef struct packed {
        logic [1:0]               count;
        result_t [MAXRES-1:0]     item;
    } push_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alnum(c) || c == CH_SLASH || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic logic is_name(input logic [7:0] c);
        return is_alnum(c) || c == CH_UNDER || c == CH_DOLLAR;
    endfunction

    // Build a result item; the last-of-run mark is set afterwards
    function automatic result_t mk(input item_kind_t k, input logic [7:0] ch,
                                   input token_kind_t tk, input logic vs,
                                   input line_status_t st);
        result_t r;
        r.item_kind   = k;
        r.out_char    = ch;
        r.token_kind  = tk;
        r.var_start   = vs;
        r.line_status = st;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

>>> design/scl_lex_core.sv
// Lexer state registers and the per-byte step logic of the shell command lexer.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_lex_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      char_byte,
    input  logic            end_of_line,
    output scl_pkg::push_t  push
);

    scl_pkg::lex_mode_t mode_reg, mode_next;
    logic               path_reg, path_next;
    logic               varne_reg, varne_next;
    logic [1:0]         err_reg, err_next;

    scl_pkg::result_t [scl_pkg::MAXRES-1:0] res;
    logic [1:0]         n;

    // One lexing step: results and next state for the held byte
    always_comb
    begin
        mode_next  = mode_reg;
        path_next  = path_reg;
        varne_next = varne_reg;
        err_next   = err_reg;
        res        = '0;
        n          = 2'd0;

        unique case (mode_reg)
            scl_pkg::MODE_IDLE:
            begin
                if (scl_pkg::is_space(char_byte))
                begin
                end
                else if (char_byte == scl_pkg::CH_SQUOTE)
                    mode_next = scl_pkg::MODE_SQ;
                else if (char_byte == scl_pkg::CH_DQUOTE)
                    mode_next = scl_pkg::MODE_DQ;
                else if (char_byte == scl_pkg::CH_DOLLAR)
                begin
                    mode_next  = scl_pkg::MODE_VAR;
                    varne_next = 1'b0;
                end
                else if (char_byte == scl_pkg::CH_PIPE)
                begin
                    res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                    res[1] = scl_pkg::mk(scl_pkg::KIND_TOKEN_END, 8'd0, scl_pkg::TOK_PIPE,
                                         1'b0, scl_pkg::ST_OK);
                    n = 2'd2;
                end
                else if (scl_pkg::is_word(char_byte))
                begin
                    mode_next = scl_pkg::MODE_WORD;
                    path_next = (char_byte == scl_pkg::CH_SLASH);
                    res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                    n = 2'd1;
                end
                else
                begin
                    err_next  = scl_pkg::ST_ILLEGAL;
                    mode_next = scl_pkg::MODE_DISC;
                end
            end
            scl_pkg::MODE_WORD:
            begin
                if (scl_pkg::is_space(char_byte))
                begin
                    res[0] = scl_pkg::mk(scl_pkg::KIND_TOKEN_END, 8'd0,
                                         path_reg ? scl_pkg::TOK_PATH : scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                    n = 2'd1;
                    mode_next = scl_pkg::MODE_IDLE;
                end
                else if (scl_pkg::is_word(char_byte))
                begin
                    if (char_byte == scl_pkg::CH_SLASH)
                        path_next = 1'b1;
                    res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                    n = 2'd1;
                end
                else
                begin
                    err_next  = scl_pkg::ST_ILLEGAL;
                    mode_next = scl_pkg::MODE_DISC;
                end
            end
            scl_pkg::MODE_VAR:
            begin
                if (scl_pkg::is_space(char_byte))
                begin
                    if (varne_reg)
                    begin
                        res[0] = scl_pkg::mk(scl_pkg::KIND_TOKEN_END, 8'd0, scl_pkg::TOK_VAR,
                                             1'b0, scl_pkg::ST_OK);
                        n = 2'd1;
                        mode_next = scl_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        err_next  = scl_pkg::ST_EMPTY_VAR;
                        mode_next = scl_pkg::MODE_DISC;
                    end
                end
                else if (scl_pkg::is_name(char_byte))
                begin
                    varne_next = 1'b1;
                    res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                    n = 2'd1;
                end
                else
                begin
                    err_next  = scl_pkg::ST_ILLEGAL;
                    mode_next = scl_pkg::MODE_DISC;
                end
            end
            scl_pkg::MODE_SQ:
            begin
                if (char_byte == scl_pkg::CH_SQUOTE)
                begin
                    res[0] = scl_pkg::mk(scl_pkg::KIND_TOKEN_END, 8'd0, scl_pkg::TOK_SQUOTE,
                                         1'b0, scl_pkg::ST_OK);
                    mode_next = scl_pkg::MODE_IDLE;
                end
                else
                    res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                n = 2'd1;
            end
            scl_pkg::MODE_DQ:
            begin
                if (char_byte == scl_pkg::CH_DQUOTE)
                begin
                    res[0] = scl_pkg::mk(scl_pkg::KIND_TOKEN_END, 8'd0, scl_pkg::TOK_DQUOTE,
                                         1'b0, scl_pkg::ST_OK);
                    n = 2'd1;
                    mode_next = scl_pkg::MODE_IDLE;
                end
                else if (char_byte == scl_pkg::CH_BSLASH)
                    mode_next = scl_pkg::MODE_DQESC;
                else if (char_byte == scl_pkg::CH_DOLLAR)
                begin
                    res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                         1'b1, scl_pkg::ST_OK);
                    n = 2'd1;
                    varne_next = 1'b0;
                    mode_next  = scl_pkg::MODE_DQVAR;
                end
                else
                begin
                    res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                    n = 2'd1;
                end
            end
            scl_pkg::MODE_DQESC:
            begin
                res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                     1'b0, scl_pkg::ST_OK);
                n = 2'd1;
                mode_next = scl_pkg::MODE_DQ;
            end
            scl_pkg::MODE_DQVAR:
            begin
                if (char_byte == scl_pkg::CH_DQUOTE || scl_pkg::is_space(char_byte))
                begin
                    if (!varne_reg)
                    begin
                        err_next  = scl_pkg::ST_EMPTY_VAR;
                        mode_next = scl_pkg::MODE_DISC;
                    end
                    else if (char_byte == scl_pkg::CH_DQUOTE)
                    begin
                        res[0] = scl_pkg::mk(scl_pkg::KIND_TOKEN_END, 8'd0,
                                             scl_pkg::TOK_DQUOTE, 1'b0, scl_pkg::ST_OK);
                        n = 2'd1;
                        mode_next = scl_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        // whitespace closes the name and stays as string content
                        res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                             1'b0, scl_pkg::ST_OK);
                        n = 2'd1;
                        mode_next = scl_pkg::MODE_DQ;
                    end
                end
                else if (scl_pkg::is_name(char_byte))
                begin
                    varne_next = 1'b1;
                    res[0] = scl_pkg::mk(scl_pkg::KIND_CHAR, char_byte, scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                    n = 2'd1;
                end
                else
                begin
                    err_next  = scl_pkg::ST_ILLEGAL;
                    mode_next = scl_pkg::MODE_DISC;
                end
            end
            scl_pkg::MODE_DISC:
            begin
            end
            default:
            begin
            end
        endcase

        // End of line: close an open token, flag open quotes or an empty variable, then the line end
        if (end_of_line)
        begin
            case (mode_next)
                scl_pkg::MODE_WORD:
                begin
                    res[n] = scl_pkg::mk(scl_pkg::KIND_TOKEN_END, 8'd0,
                                         path_next ? scl_pkg::TOK_PATH : scl_pkg::TOK_WORD,
                                         1'b0, scl_pkg::ST_OK);
                    n = n + 2'd1;
                end
                scl_pkg::MODE_VAR:
                begin
                    if (varne_next)
                    begin
                        res[n] = scl_pkg::mk(scl_pkg::KIND_TOKEN_END, 8'd0, scl_pkg::TOK_VAR,
                                             1'b0, scl_pkg::ST_OK);
                        n = n + 2'd1;
                    end
                    else
                    begin
                        err_next = scl_pkg::ST_EMPTY_VAR;
                        n = 2'd0;
                    end
                end
                scl_pkg::MODE_SQ, scl_pkg::MODE_DQ, scl_pkg::MODE_DQESC,
                scl_pkg::MODE_DQVAR:
                begin
                    err_next = scl_pkg::ST_UNCLOSED;
                    n = 2'd0;
                end
                default:
                begin
                end
            endcase
            res[n] = scl_pkg::mk(scl_pkg::KIND_LINE_END, 8'd0, scl_pkg::TOK_WORD, 1'b0,
                                 scl_pkg::line_status_t'(err_next));
            n = n + 2'd1;
            mode_next  = scl_pkg::MODE_IDLE;
            path_next  = 1'b0;
            varne_next = 1'b0;
            err_next   = scl_pkg::ST_OK;
        end

        // Results of an erroring byte are dropped and discard mode emits nothing, but for the line end
        if (mode_next == scl_pkg::MODE_DISC)
            n = 2'd0;

        if (n != 2'd0)
            res[n - 2'd1].last_of_run = 1'b1;
    end

    // Hand the results to the queue only when the step really fires
    always_comb
    begin
        push.item  = res;
        push.count = fire ? n : 2'd0;
    end

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= scl_pkg::MODE_IDLE;
            path_reg  <= 1'b0;
            varne_reg <= 1'b0;
            err_reg   <= 2'd0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            path_reg  <= path_next;
            varne_reg <= varne_next;
            err_reg   <= err_next;
        end
    end

endmodule

>>> design/scl_out_queue.sv
// Result queue of the shell command lexer: takes up to three items a cycle, gives one while out_ready is high.
// Depends on scl_pkg.
`timescale 1ns / 1ps

module scl_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  scl_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output scl_pkg::result_t out_item
);

    scl_pkg::result_t         mem_reg [scl_pkg::QDEPTH];
    logic [scl_pkg::QAW-1:0]  wr_reg, wr_next;
    logic [scl_pkg::QAW-1:0]  rd_reg, rd_next;
    logic [scl_pkg::QCW-1:0]  cnt_reg, cnt_next;
    logic                     pop;

    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // space for a full burst of one step
    assign room      = (cnt_reg <= scl_pkg::QCW'(scl_pkg::QDEPTH - scl_pkg::MAXRES));

    // Pointer and fill arithmetic
    always_comb
    begin
        wr_next  = wr_reg + scl_pkg::QAW'(push.count);
        rd_next  = rd_reg + scl_pkg::QAW'(pop);
        cnt_next = cnt_reg + scl_pkg::QCW'(push.count) - scl_pkg::QCW'(pop);
    end

    // Storage: lane i goes to the i-th free slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < scl_pkg::MAXRES; i++)
        begin
            if (i < int'(push.count))
                mem_reg[wr_reg + scl_pkg::QAW'(i)] <= push.item[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> design/shell_command_lexer_unit.sv
// Top level of the shell command lexer: input register, lexing step and result queue.
// Depends on scl_pkg, scl_lex_core and scl_out_queue.
`timescale 1ns / 1ps

// Usage
//   Slave side: one byte of a command line per item on s_tdata, s_tlast set on
//   the line's last byte. Master side: one result item per handshake; m_tuser
//   gives the item kind (content character, token end, line end) and the
//   var_start flag, m_tdata the character, token kind and line status, and
//   m_tlast marks the final result caused by one input byte.
//   Order: an accepted byte is held in the input register and lexed there once
//   the queue has room; its results are written to the result queue and offered.
//   Throughput: one byte per cycle while each byte yields at most one result and
//   m_tready stays high. A token end or line end can add up to two results for
//   one byte; the eight entry result queue absorbs these. The output drains one
//   result per cycle while m_tready is high, so a long stream sustains no more.
//   Reset: the lexer returns to idle between tokens with no error, and the
//   queue and input register empty.
//   Stall: when the receiver holds m_tready low the queue fills; the lexing
//   step waits once fewer than three slots remain, and s_tready drops as soon
//   as the input register is also held.
module shell_command_lexer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_byte
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [10:8] token_kind, [12:11] line_status
    output logic [2:0]  m_tuser,   // [1:0] item_kind, [2] var_start
    output logic        m_tlast    // last_of_run
);

    logic              in_valid_reg;
    logic [7:0]        in_char_reg;
    logic              in_eol_reg;
    logic              room;
    logic              fire;
    scl_pkg::push_t    push;
    scl_pkg::result_t  out_item;

    assign fire     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_eol_reg  <= s_tlast;
        end
    end

    scl_lex_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .char_byte   (in_char_reg),
        .end_of_line (in_eol_reg),
        .push        (push)
    );

    scl_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Output packing
    assign m_tdata = {3'b000, out_item.line_status, out_item.token_kind, out_item.out_char};
    assign m_tuser = {out_item.var_start, out_item.item_kind};
    assign m_tlast = out_item.last_of_run;

endmodule
